@@ hw/rtl/qsl_pkg.sv @@
// qsl_pkg: constants, types and step functions for the quaternion slerp pipeline.
// Used by qsl_sin and quaternion_slerp. No dependencies.
package qsl_pkg;

  localparam int THR_W = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd29491;   // 0.9 in Q0.15

  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // acos polynomial coefficients, Q.15
  localparam logic [9:0]  ACOS_C3 = 10'd614;
  localparam logic [11:0] ACOS_C2 = 12'd2433;
  localparam logic [12:0] ACOS_C1 = 13'd6951;
  localparam logic [15:0] ACOS_C0 = 16'd51470;

  // sine series divisors and their scaled reciprocals (2^24 / d)
  localparam logic [5:0]  SIN_D3 = 6'd42;
  localparam logic [5:0]  SIN_D2 = 6'd20;
  localparam logic [5:0]  SIN_D1 = 6'd6;
  localparam logic [21:0] RECIP_D3 = 22'((32'd1 << 24) / 42);
  localparam logic [21:0] RECIP_D2 = 22'((32'd1 << 24) / 20);
  localparam logic [21:0] RECIP_D1 = 22'((32'd1 << 24) / 6);

  typedef struct packed {
    logic [30:0] v;
    logic [31:0] r;
  } isq_t;

  typedef struct packed {
    logic [15:0] rem;
    logic [14:0] q;
  } div_st_t;

  // one digit of the bitwise integer square root
  function automatic isq_t isq_step(isq_t s, logic [31:0] bitv);
    isq_t        o;
    logic [32:0] trial;
    logic [32:0] vx;
    trial = {1'b0, s.r} + {1'b0, bitv};
    vx    = {2'b00, s.v};
    if (vx >= trial) begin
      o.v = 31'(vx - trial);
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one bit of restoring division, remainder kept below den
  function automatic div_st_t div_step(div_st_t s, logic [15:0] den);
    div_st_t     o;
    logic [16:0] rem2;
    rem2 = {s.rem, 1'b0};
    if (rem2 >= {1'b0, den}) begin
      o.rem = 16'(rem2 - {1'b0, den});
      o.q   = {s.q[13:0], 1'b1};
    end else begin
      o.rem = rem2[15:0];
      o.q   = {s.q[13:0], 1'b0};
    end
    return o;
  endfunction

  // floor(x / dv) for x below 2^18: reciprocal multiply, then one correction
  function automatic logic [17:0] div_const(logic [17:0] x, logic [21:0] recip,
                                            logic [5:0] dv);
    logic [39:0] prod;
    logic [17:0] q;
    logic [23:0] qd;
    logic [17:0] r;
    prod = {22'b0, x} * {18'b0, recip};
    q    = {2'b00, prod[39:24]};
    qd   = {6'b0, q} * {18'b0, dv};
    r    = x - qd[17:0];
    if (r >= {12'b0, dv}) q = q + 18'd1;
    return q;
  endfunction

endpackage

@@ hw/rtl/qsl_sin.sv @@
// qsl_sin: seven-stage fixed-point sine (odd series in nested form), Q.15 angle in.
// Depends on qsl_pkg. Stage enables come from the parent's stall chain.
module qsl_sin (
  input  logic        clk,
  input  logic [6:0]  en,
  input  logic [15:0] ang,
  output logic [15:0] sin_val
);
  import qsl_pkg::*;

  logic [15:0] a0_r, a1_r, a2_r, a3_r, a4_r, a5_r;
  logic [16:0] sq0_r, sq1_r, sq2_r, sq3_r;
  logic [15:0] k3_r, k2_r, k1_r;
  logic [16:0] m2_r, m4_r;
  logic [15:0] s6_r;

  logic [31:0] sq_nxt;
  logic [32:0] m2_nxt, m4_nxt;
  logic [17:0] q1, q3, q5;
  logic [31:0] s_prod;
  logic [16:0] s_raw;

  always_comb begin
    sq_nxt = {16'b0, ang} * {16'b0, ang};
    q1     = div_const({1'b0, sq0_r}, RECIP_D3, SIN_D3);
    m2_nxt = {16'b0, sq1_r} * {17'b0, k3_r};
    q3     = div_const({1'b0, m2_r}, RECIP_D2, SIN_D2);
    m4_nxt = {16'b0, sq3_r} * {17'b0, k2_r};
    q5     = div_const({1'b0, m4_r}, RECIP_D1, SIN_D1);
    s_prod = {16'b0, a5_r} * {16'b0, k1_r};
    s_raw  = s_prod[31:15];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a0_r  <= ang;
      sq0_r <= sq_nxt[31:15];
    end
    if (en[1]) begin
      a1_r  <= a0_r;
      sq1_r <= sq0_r;
      k3_r  <= ONE_Q15 - q1[15:0];
    end
    if (en[2]) begin
      a2_r  <= a1_r;
      sq2_r <= sq1_r;
      m2_r  <= m2_nxt[31:15];
    end
    if (en[3]) begin
      a3_r  <= a2_r;
      sq3_r <= sq2_r;
      k2_r  <= ONE_Q15 - q3[15:0];
    end
    if (en[4]) begin
      a4_r <= a3_r;
      m4_r <= m4_nxt[31:15];
    end
    if (en[5]) begin
      a5_r <= a4_r;
      k1_r <= ONE_Q15 - q5[15:0];
    end
    if (en[6]) begin
      s6_r <= (s_raw > {1'b0, ONE_Q15}) ? ONE_Q15 : s_raw[15:0];
    end
  end

  assign sin_val = s6_r;

endmodule

@@ hw/rtl/quaternion_slerp.sv @@
// quaternion_slerp: 21-stage pipelined spherical linear interpolation of two quaternions.
// Depends on qsl_pkg and qsl_sin.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+---------------------------------------------
//  in_     | in  | in_tvalid/tready   | a_w..a_z, b_w..b_z (COMP_WIDTH each), blend
//  out_    | out | out_tvalid/tready  | r_w..r_z (COMP_WIDTH each), zero padded
//  cfg_    | in  | cfg_wr_en          | linear_threshold (15 bits)
//
// out_tvalid is the valid bit of stage 21 and rises when the accepted item is loaded there;
// one item per cycle sustained while out_tready stays high.
// The depth is set by the acos chain (polynomial plus a 16-digit square root over
// four stages), three parallel seven-stage sine units and two 15-bit dividers.
// Each stage has its own valid bit; a stage loads when empty or when the next one
// loads, so bubbles are squeezed out and the input keeps flowing while a result waits
// and an empty stage remains ahead of it.
// rst_n (synchronous, active low) empties the pipe and reloads the threshold.
module quaternion_slerp #(
  parameter int COMP_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [qsl_pkg::THR_W-1:0]             cfg_wr_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend[15:0] (lowest first)
  input  logic [8*COMP_WIDTH+15:0]              in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // r_w, r_x, r_y, r_z (lowest first), zero fill to whole bytes
  output logic [((4*COMP_WIDTH+7)/8)*8-1:0]     out_tdata
);
  import qsl_pkg::*;

  localparam int W      = COMP_WIDTH;
  localparam int DW     = 2 * W;
  localparam int NS     = 21;
  localparam int SW     = 8 * W + 18;
  localparam int T_LO   = 8 * W;
  localparam int NEG_B  = 8 * W + 16;
  localparam int LIN_B  = 8 * W + 17;
  localparam int DSH    = 2 * W - 19;       // dot magnitude down to 15 fraction bits
  localparam int OUT_W  = ((4 * W + 7) / 8) * 8;

  // ---------------- stall chain and valid bits ----------------
  logic [NS:1] v_r;
  logic [NS:1] adv;

  always_comb begin
    adv[NS] = !v_r[NS] || out_tready;
    for (int k = NS - 1; k >= 1; k--) adv[k] = !v_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= in_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_tready  = adv[1];
  assign out_tvalid = v_r[NS];

  // ---------------- threshold register ----------------
  logic [THR_W-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // ---------------- side band: a, b, t, neg, lin travel with the item ----------------
  logic [SW-1:0] side_r [1:NS-1];

  // ---------------- stage 1: component products ----------------
  logic signed [DW-3:0] pq_r [4];
  logic [15:0]          t_sat;

  always_comb begin
    t_sat = (in_tdata[T_LO +: 16] > ONE_Q15) ? ONE_Q15 : in_tdata[T_LO +: 16];
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      side_r[1] <= {2'b00, t_sat, in_tdata[8*W-1:0]};
      for (int i = 0; i < 4; i++) begin
        pq_r[i] <= (DW-2)'(DW'($signed(in_tdata[i*W +: W]) *
                               $signed(in_tdata[(4+i)*W +: W])) >>> 2);
      end
    end
  end

  // ---------------- stage 2: dot, short-path sign, threshold test ----------------
  logic signed [DW-1:0] dot;
  logic [DW-1:0]        mag;
  logic [17:0]          dmag;
  logic                 dneg, dlin;
  logic [14:0]          dq_r;

  always_comb begin
    dot  = DW'(pq_r[0]) + DW'(pq_r[1]) + DW'(pq_r[2]) + DW'(pq_r[3]);
    dneg = dot[DW-1];
    mag  = dneg ? unsigned'(-dot) : unsigned'(dot);
    dmag = mag[DSH +: 18];
    dlin = dmag >= {3'b000, thr_r};
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      side_r[2] <= {dlin, dneg, side_r[1][NEG_B-1:0]};
      dq_r      <= dmag[14:0];
    end
  end

  for (genvar k = 3; k <= NS - 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv[k]) side_r[k] <= side_r[k-1];
    end
  end

  // ---------------- stages 3-5: acos polynomial ----------------
  logic [14:0] dq3_r, dq4_r;
  logic [11:0] u1_r;
  logic [12:0] u2_r;
  logic [15:0] p5_r, p6_r;
  logic [24:0] m1;
  logic [26:0] m2;
  logic [27:0] m3;

  always_comb begin
    m1 = {15'b0, ACOS_C3} * {10'b0, dq_r};
    m2 = {15'b0, u1_r} * {12'b0, dq3_r};
    m3 = {15'b0, u2_r} * {13'b0, dq4_r};
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dq3_r <= dq_r;
      u1_r  <= ACOS_C2 - {2'b00, m1[24:15]};
    end
    if (adv[4]) begin
      dq4_r <= dq3_r;
      u2_r  <= ACOS_C1 - {1'b0, m2[26:15]};
    end
    if (adv[5]) p5_r <= ACOS_C0 - {3'b000, m3[27:15]};
    if (adv[6]) p6_r <= p5_r;
  end

  // ---------------- stages 3-6: square root of (1-d), four digits a stage ----------------
  isq_t        isq_r [4];
  logic [15:0] rad;

  assign rad = ONE_Q15 - {1'b0, dq_r};

  for (genvar g = 0; g < 4; g++) begin : g_isq
    isq_t isq_nxt;
    always_comb begin
      logic [31:0] bitv;
      if (g == 0) begin
        isq_nxt.v = {rad, 15'b0};
        isq_nxt.r = '0;
      end else begin
        isq_nxt = isq_r[(g > 0) ? g - 1 : 0];
      end
      for (int j = 0; j < 4; j++) begin
        bitv    = 32'd1 << (30 - 2 * (4 * g + j));
        isq_nxt = isq_step(isq_nxt, bitv);
      end
    end
    always_ff @(posedge clk) begin
      if (adv[3+g]) isq_r[g] <= isq_nxt;
    end
  end

  // ---------------- stage 7: theta ----------------
  logic [31:0] th_prod;
  logic [15:0] th7_r;

  assign th_prod = {16'b0, isq_r[3].r[15:0]} * {16'b0, p6_r};

  always_ff @(posedge clk) begin
    if (adv[7]) th7_r <= th_prod[30:15];
  end

  // ---------------- stage 8: partial angles ----------------
  logic [15:0] t7, th8_r, an1_r, an2_r;
  logic [31:0] an1_prod, an2_prod;

  always_comb begin
    t7       = side_r[7][T_LO +: 16];
    an1_prod = {16'b0, ONE_Q15 - t7} * {16'b0, th7_r};
    an2_prod = {16'b0, t7} * {16'b0, th7_r};
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      th8_r <= th7_r;
      an1_r <= an1_prod[30:15];
      an2_r <= an2_prod[30:15];
    end
  end

  // ---------------- stages 9-15: three sines ----------------
  logic [15:0] st_w, sn1_w, sn2_w;

  qsl_sin u_sin_th (.clk(clk), .en(adv[15:9]), .ang(th8_r), .sin_val(st_w));
  qsl_sin u_sin_1  (.clk(clk), .en(adv[15:9]), .ang(an1_r), .sin_val(sn1_w));
  qsl_sin u_sin_2  (.clk(clk), .en(adv[15:9]), .ang(an2_r), .sin_val(sn2_w));

  // ---------------- stages 16-19: weight division, 15 quotient bits ----------------
  // A numerator at or above the divisor saturates the weight at one.
  div_st_t     dv1_r [4];
  div_st_t     dv2_r [4];
  logic [15:0] den_r [4];
  logic        big1_r [4];
  logic        big2_r [4];

  for (genvar g = 0; g < 4; g++) begin : g_div
    localparam int NSTEP = (g == 3) ? 3 : 4;
    div_st_t     d1_nxt, d2_nxt;
    logic [15:0] den_nxt;
    logic        b1_nxt, b2_nxt;
    always_comb begin
      if (g == 0) begin
        d1_nxt  = '{rem: sn1_w, q: '0};
        d2_nxt  = '{rem: sn2_w, q: '0};
        den_nxt = st_w;
        b1_nxt  = sn1_w >= st_w;
        b2_nxt  = sn2_w >= st_w;
      end else begin
        d1_nxt  = dv1_r[(g > 0) ? g - 1 : 0];
        d2_nxt  = dv2_r[(g > 0) ? g - 1 : 0];
        den_nxt = den_r[(g > 0) ? g - 1 : 0];
        b1_nxt  = big1_r[(g > 0) ? g - 1 : 0];
        b2_nxt  = big2_r[(g > 0) ? g - 1 : 0];
      end
      for (int j = 0; j < NSTEP; j++) begin
        d1_nxt = div_step(d1_nxt, den_nxt);
        d2_nxt = div_step(d2_nxt, den_nxt);
      end
    end
    always_ff @(posedge clk) begin
      if (adv[16+g]) begin
        dv1_r[g]  <= d1_nxt;
        dv2_r[g]  <= d2_nxt;
        den_r[g]  <= den_nxt;
        big1_r[g] <= b1_nxt;
        big2_r[g] <= b2_nxt;
      end
    end
  end

  // ---------------- stage 20: weight select and weighted terms ----------------
  // Linear weights when at or over threshold or when sin(theta) is zero.
  logic [15:0]          t19, w1, w2, s1, s2;
  logic                 use_lin;
  logic signed [W+16:0] p1_r [4];
  logic signed [W+16:0] p2_r [4];

  always_comb begin
    t19     = side_r[19][T_LO +: 16];
    use_lin = side_r[19][LIN_B] || (den_r[3] == 16'd0);
    w1      = big1_r[3] ? ONE_Q15 : {1'b0, dv1_r[3].q};
    w2      = big2_r[3] ? ONE_Q15 : {1'b0, dv2_r[3].q};
    s1      = use_lin ? (ONE_Q15 - t19) : w1;
    s2      = use_lin ? t19 : w2;
  end

  always_ff @(posedge clk) begin
    if (adv[20]) begin
      for (int i = 0; i < 4; i++) begin
        p1_r[i] <= $signed({1'b0, s1}) * $signed(side_r[19][i*W +: W]);
        p2_r[i] <= $signed({1'b0, s2}) * $signed(side_r[19][(4+i)*W +: W]);
      end
    end
  end

  // ---------------- stage 21: combine, round, saturate ----------------
  logic [W-1:0] res_r [4];
  logic [W-1:0] res_nxt [4];

  always_comb begin
    logic signed [W+17:0] acc;
    logic signed [W+2:0]  rs;
    logic                 ovp, ovn;
    for (int i = 0; i < 4; i++) begin
      acc = side_r[20][NEG_B] ? ((W+18)'(p1_r[i]) - (W+18)'(p2_r[i]))
                              : ((W+18)'(p1_r[i]) + (W+18)'(p2_r[i]));
      acc = acc + (W+18)'(16384);
      rs  = acc[W+17:15];
      ovp = !rs[W+2] && (|rs[W+1:W-1]);
      ovn = rs[W+2] && !(&rs[W+1:W-1]);
      if (ovp)      res_nxt[i] = {1'b0, {(W-1){1'b1}}};
      else if (ovn) res_nxt[i] = {1'b1, {(W-1){1'b0}}};
      else          res_nxt[i] = rs[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[21]) begin
      for (int i = 0; i < 4; i++) res_r[i] <= res_nxt[i];
    end
  end

  assign out_tdata = OUT_W'({res_r[3], res_r[2], res_r[1], res_r[0]});

  // ---------------- checks ----------------
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[1])
    else $error("accepted item did not enter stage 1");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[10] && !adv[10] |=> v_r[10])
    else $error("stalled item lost in sine stages");

  a_theta: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[7] |-> th7_r <= ACOS_C0)
    else $error("theta beyond pi/2");

  a_sine: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[15] |-> (st_w <= ONE_Q15) && (sn1_w <= ONE_Q15) && (sn2_w <= ONE_Q15))
    else $error("sine above one");

endmodule
